@@ hw/rtl/sobel_pkg.sv @@
// Shared types, constants and helpers for the Sobel edge detector.
`default_nettype none
package sobel_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 20;
  localparam int MAG_W      = 21;
  localparam int THR_W      = 11;
  localparam int THR_SQ_W   = 2 * THR_W;
  localparam int FWIDTH_W   = 11;
  localparam int FHEIGHT_W  = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Result queue behind the arithmetic pipeline
  localparam int QDEPTH     = 16;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  localparam logic [FWIDTH_W-1:0]  RESET_FRAME_WIDTH  = 11'd640;
  localparam logic [FHEIGHT_W-1:0] RESET_FRAME_HEIGHT = 12'd480;
  localparam logic [THR_W-1:0]     RESET_THRESHOLD    = 11'd100;
  localparam logic [FWIDTH_W-1:0]  MIN_DIM            = 11'd3;
  localparam logic [FWIDTH_W-1:0]  MAX_DIM            = FWIDTH_W'(MAX_WIDTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_THRESHOLD    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     last;
  } lane_t;

  typedef struct packed {
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [MAG_W-1:0]         mag;
    logic                     edge_flag;
    logic                     last;
  } result_t;

  // (pa + 2 pb + pc) - (na + 2 nb + nc), range fits the gradient width
  function automatic logic signed [GRAD_W-1:0] sobel_diff(
    input logic [PIX_W-1:0] pa, input logic [PIX_W-1:0] pb, input logic [PIX_W-1:0] pc,
    input logic [PIX_W-1:0] na, input logic [PIX_W-1:0] nb, input logic [PIX_W-1:0] nc
  );
    logic [GRAD_W:0] pos;
    logic [GRAD_W:0] neg;
    logic [GRAD_W:0] dif;
    pos = {4'b0, pa} + {3'b0, pb, 1'b0} + {4'b0, pc};
    neg = {4'b0, na} + {3'b0, nb, 1'b0} + {4'b0, nc};
    dif = pos - neg;
    return dif[GRAD_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sobel_gradient_edge_detect.sv @@
// Streaming 3x3 Sobel gradient and edge flag with line memory and result queue.
// Throughput: one pixel per cycle while in_stall is low; from the third row on,
// a row of N pixels yields N results, the row's last pixel yields two, and the
// output port drains one word per cycle while out_stall is low.
// in_stall rises only when the 16-entry queue cannot take the pixel's results.
// Reset (synchronous, rst_n low) clears counters, window, queue, valid flags;
// the line memory is not cleared and needs no clearing pass.
`default_nettype none
module sobel_gradient_edge_detect import sobel_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [PIX_W-1:0]         in_pixel,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [ROW_W-1:0]              out_row,
  output logic [COL_W-1:0]              out_col,
  output logic signed [GRAD_W-1:0]      out_gradient_x,
  output logic signed [GRAD_W-1:0]      out_gradient_y,
  output logic [MAG_W-1:0]              out_magnitude_sq,
  output logic                          out_is_edge,
  output logic                          out_last_of_run,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

  // Configuration
  logic [FWIDTH_W-1:0]  frame_width_r;
  logic [FHEIGHT_W-1:0] frame_height_r;
  logic [THR_W-1:0]     threshold_r;
  logic [THR_SQ_W-1:0]  thr_sq_r;

  // Frame position
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Line memory word: {line_prev2, line_prev}
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_q_r;

  // Read stage
  logic             rd_valid_r;
  logic [PIX_W-1:0] rd_px_r;
  logic [COL_W-1:0] rd_col_r;
  logic [ROW_W-1:0] rd_row_r;
  logic             rd_emit0_r, rd_emit1_r, rd_first_r, rd_last0_r;

  // Window [row top..bottom][col left..right]
  logic [PIX_W-1:0] win_r   [3][3];
  logic [PIX_W-1:0] win_nxt [3][3];

  // Gradient and square stages, two lanes
  logic [1:0]       s1_vld_r;
  lane_t            s1_lane_r [2];
  lane_t            lane_nxt  [2];
  logic [1:0]       s2_vld_r;
  lane_t            s2_lane_r [2];
  logic [SQ_W-1:0]  s2_sqx_r  [2];
  logic [SQ_W-1:0]  s2_sqy_r  [2];
  result_t          res       [2];

  // Result queue
  result_t           queue_r [QDEPTH];
  logic [QCNT_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] used_r, used_nxt;

  logic [FWIDTH_W-1:0]  w_eff, w_last;
  logic [FHEIGHT_W-1:0] h_eff, h_last;
  logic                 row_end, interior;
  logic [1:0]           n_cur;
  logic                 in_acc, out_acc;
  logic [QCNT_W:0]      need;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RESET_FRAME_WIDTH;
      frame_height_r <= RESET_FRAME_HEIGHT;
      threshold_r    <= RESET_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FWIDTH_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FHEIGHT_W-1:0];
        CFG_THRESHOLD:    threshold_r    <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= THR_SQ_W'(threshold_r) * THR_SQ_W'(threshold_r);
  end

  // Position decode on the current counters
  always_comb begin
    w_eff = frame_width_r;
    if (frame_width_r < MIN_DIM) w_eff = MIN_DIM;
    if (frame_width_r > MAX_DIM) w_eff = MAX_DIM;
    w_last   = w_eff - 1'b1;
    h_eff    = (frame_height_r < FHEIGHT_W'(MIN_DIM)) ? FHEIGHT_W'(MIN_DIM) : frame_height_r;
    h_last   = h_eff - 1'b1;
    row_end  = {1'b0, col_r} >= w_last;
    interior = (row_r >= ROW_W'(2)) && (row_r <= h_last);
    n_cur    = {1'b0, interior && (col_r != '0)} + {1'b0, interior && row_end};
    if (row_end) begin
      col_nxt = '0;
      row_nxt = (row_r >= h_last) ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
      row_nxt = row_r;
    end
  end

  // Reserve queue room for every result still in flight
  assign need     = {1'b0, used_r} + {{(QCNT_W-1){1'b0}}, n_cur};
  assign in_stall = need > (QCNT_W+1)'(QDEPTH);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  always_comb begin
    used_nxt = used_r;
    if (in_acc) used_nxt = used_nxt + {{(QCNT_W-2){1'b0}}, n_cur};
    if (out_acc) used_nxt = used_nxt - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      used_r     <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      used_r     <= used_nxt;
      rd_valid_r <= in_acc;
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_px_r    <= in_pixel;
      rd_col_r   <= col_r;
      rd_row_r   <= row_r - 1'b1;
      rd_emit0_r <= interior && (col_r != '0);
      rd_emit1_r <= interior && row_end;
      rd_first_r <= col_r == COL_W'(1);
      rd_last0_r <= !row_end;
    end
  end

  // Line memory: read on accept, write back in the following cycle. Consecutive
  // pixels always hit different columns, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (in_acc) mem_q_r <= line_mem[col_r];
    if (rd_valid_r) line_mem[rd_col_r] <= {mem_q_r[PIX_W-1:0], rd_px_r};
  end

  // Shift the window left and bring in the new column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = mem_q_r[2*PIX_W-1:PIX_W];
    win_nxt[1][2] = mem_q_r[PIX_W-1:0];
    win_nxt[2][2] = rd_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win_r[i][j] <= '0;
    end else if (rd_valid_r) begin
      win_r <= win_nxt;
    end
  end

  // Lane 0: pixel left of the new column; lane 1: last column of the row
  always_comb begin
    logic [PIX_W-1:0] tl0, ml0, bl0;
    tl0 = rd_first_r ? win_nxt[0][1] : win_nxt[0][0];
    ml0 = rd_first_r ? win_nxt[1][1] : win_nxt[1][0];
    bl0 = rd_first_r ? win_nxt[2][1] : win_nxt[2][0];
    lane_nxt[0].row  = rd_row_r;
    lane_nxt[0].col  = rd_col_r - 1'b1;
    lane_nxt[0].gx   = sobel_diff(win_nxt[0][2], win_nxt[1][2], win_nxt[2][2], tl0, ml0, bl0);
    lane_nxt[0].gy   = sobel_diff(bl0, win_nxt[2][1], win_nxt[2][2],
                                  tl0, win_nxt[0][1], win_nxt[0][2]);
    lane_nxt[0].last = rd_last0_r;
    lane_nxt[1].row  = rd_row_r;
    lane_nxt[1].col  = rd_col_r;
    lane_nxt[1].gx   = sobel_diff(win_nxt[0][2], win_nxt[1][2], win_nxt[2][2],
                                  win_nxt[0][1], win_nxt[1][1], win_nxt[2][1]);
    lane_nxt[1].gy   = sobel_diff(win_nxt[2][1], win_nxt[2][2], win_nxt[2][2],
                                  win_nxt[0][1], win_nxt[0][2], win_nxt[0][2]);
    lane_nxt[1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= '0;
      s2_vld_r <= '0;
    end else begin
      s1_vld_r <= {rd_valid_r && rd_emit1_r, rd_valid_r && rd_emit0_r};
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [2*GRAD_W-1:0] px, py;
    for (int k = 0; k < 2; k++) begin
      s1_lane_r[k] <= lane_nxt[k];
      px = s1_lane_r[k].gx * s1_lane_r[k].gx;
      py = s1_lane_r[k].gy * s1_lane_r[k].gy;
      s2_lane_r[k] <= s1_lane_r[k];
      s2_sqx_r[k]  <= px[SQ_W-1:0];
      s2_sqy_r[k]  <= py[SQ_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      res[k].row       = s2_lane_r[k].row;
      res[k].col       = s2_lane_r[k].col;
      res[k].gx        = s2_lane_r[k].gx;
      res[k].gy        = s2_lane_r[k].gy;
      res[k].mag       = {1'b0, s2_sqx_r[k]} + {1'b0, s2_sqy_r[k]};
      res[k].edge_flag = {1'b0, res[k].mag} > thr_sq_r;
      res[k].last      = s2_lane_r[k].last;
    end
  end

  // Queue: push up to two words in order, pop one
  always_ff @(posedge clk) begin
    if (s2_vld_r[0]) queue_r[wp_r[QPTR_W-1:0]] <= res[0];
    if (s2_vld_r[1]) begin
      if (s2_vld_r[0]) queue_r[QPTR_W'(wp_r[QPTR_W-1:0] + 1'b1)] <= res[1];
      else             queue_r[wp_r[QPTR_W-1:0]] <= res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_r + {{(QCNT_W-1){1'b0}}, s2_vld_r[0]} + {{(QCNT_W-1){1'b0}}, s2_vld_r[1]};
      if (out_acc) rp_r <= rp_r + 1'b1;
    end
  end

  assign out_valid        = wp_r != rp_r;
  assign out_row          = queue_r[rp_r[QPTR_W-1:0]].row;
  assign out_col          = queue_r[rp_r[QPTR_W-1:0]].col;
  assign out_gradient_x   = queue_r[rp_r[QPTR_W-1:0]].gx;
  assign out_gradient_y   = queue_r[rp_r[QPTR_W-1:0]].gy;
  assign out_magnitude_sq = queue_r[rp_r[QPTR_W-1:0]].mag;
  assign out_is_edge      = queue_r[rp_r[QPTR_W-1:0]].edge_flag;
  assign out_last_of_run  = queue_r[rp_r[QPTR_W-1:0]].last;

  // Reserved count never exceeds the queue depth
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= QCNT_W'(QDEPTH))
    else $error("result reservation exceeds queue depth");

  // Words held in the queue are always covered by the reservation
  a_queue_covered: assert property (@(posedge clk) disable iff (!rst_n)
    QCNT_W'(wp_r - rp_r) <= used_r)
    else $error("queue holds more words than reserved");

  // An accepted pixel reaches the read stage in the next cycle
  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> rd_valid_r)
    else $error("accepted pixel missing in read stage");

  // Two results from one pixel: only the second closes the run
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r == 2'b11) |-> (!s1_lane_r[0].last && s1_lane_r[1].last))
    else $error("row-end pair carries wrong last flags");

  // A stalled result word stays presented
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(rp_r)))
    else $error("stalled result word dropped");

endmodule
`default_nettype wire
